@@ design/assert_macros.svh @@
// assertion macros for the timer queue rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SDTQ_ASSERT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SDTQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sdtq_pkg.sv @@
// shared constants and controller/datapath interface types for the timer queue
package sdtq_pkg;

    localparam int ENTRIES   = 16;
    localparam int TIME_BITS = 48;
    localparam int SLOT_W    = 4;
    localparam int DELAY_W   = 32;
    localparam int ACT_W     = 3;
    localparam int KIND_W    = 2;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);

    localparam logic [CNT_W-1:0] ENTRY_CNT = CNT_W'(ENTRIES);

    // action codes
    localparam logic [ACT_W-1:0] ACT_REARM      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CANCEL     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY      = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RUN        = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CANCEL_ALL = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_EXPIRED   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CANCELLED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE      = 2'd2;

    typedef struct packed {
        logic load;         // capture a new input word
        logic unlink;       // drop the item slot from the list
        logic idx_inc;      // advance the walk index
        logic insert;       // place the item slot at the walk index
        logic pop;          // emit head as expired and drop it
        logic call_emit;    // emit entry at walk index as cancelled
        logic call_clear;   // empty the list
        logic emit_cancel;  // emit item slot as cancelled
        logic emit_done;    // emit completion word
    } dp_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             slot_ok;
        logic             pending;
        logic             match;
        logic             idx_lt_cnt;
        logic             later;
        logic             expired;
        logic             out_free;
    } dp_sts_t;

endpackage

@@ design/sdtq_ctrl.sv @@
// controller state machine sequencing one timer action at a time
module sdtq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sdtq_pkg::dp_sts_t sts,
    output sdtq_pkg::dp_cmd_t cmd
);
    import sdtq_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DECODE = 8'b0000_0010,
        ST_UNLINK = 8'b0000_0100,
        ST_CANCEL = 8'b0000_1000,
        ST_INSERT = 8'b0001_0000,
        ST_RUN    = 8'b0010_0000,
        ST_CALL   = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (sts.action)
                    ACT_REARM: begin
                        if (!sts.slot_ok) state_next = ST_DONE;
                        else if (sts.pending) state_next = ST_UNLINK;
                        else state_next = ST_INSERT;
                    end
                    ACT_CANCEL: begin
                        if (sts.slot_ok && sts.pending) state_next = ST_UNLINK;
                        else state_next = ST_DONE;
                    end
                    ACT_RUN:        state_next = ST_RUN;
                    ACT_CANCEL_ALL: state_next = ST_CALL;
                    default:        state_next = ST_DONE;
                endcase
            end
            ST_UNLINK: begin
                if (sts.match || !sts.idx_lt_cnt) begin
                    cmd.unlink = 1'b1;
                    state_next = (sts.action == ACT_REARM) ? ST_INSERT : ST_CANCEL;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_CANCEL: begin
                if (sts.out_free) begin
                    cmd.emit_cancel = 1'b1;
                    state_next      = ST_DONE;
                end
            end
            ST_INSERT: begin
                if (sts.idx_lt_cnt && sts.later) begin
                    cmd.idx_inc = 1'b1;
                end else begin
                    cmd.insert = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_RUN: begin
                if (!sts.expired) begin
                    state_next = ST_DONE;
                end else if (sts.out_free) begin
                    cmd.pop = 1'b1;
                end
            end
            ST_CALL: begin
                if (!sts.idx_lt_cnt) begin
                    cmd.call_clear = 1'b1;
                    state_next     = ST_DONE;
                end else if (sts.out_free) begin
                    cmd.call_emit = 1'b1;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.emit_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/sdtq_datapath.sv @@
// timer list storage, walk index, compare logic and result word register
`include "assert_macros.svh"

module sdtq_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [sdtq_pkg::ACT_W-1:0]          s_action,
    input  logic [sdtq_pkg::SLOT_W-1:0]         s_slot,
    input  logic [sdtq_pkg::DELAY_W-1:0]        s_delay,
    input  logic [sdtq_pkg::TIME_BITS-1:0]      s_now,
    input  sdtq_pkg::dp_cmd_t                   cmd,
    output sdtq_pkg::dp_sts_t                   sts,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [sdtq_pkg::KIND_W-1:0]         m_kind,
    output logic [sdtq_pkg::SLOT_W-1:0]         m_which_slot,
    output logic                                m_is_pending,
    output logic                                m_was_empty,
    output logic [sdtq_pkg::TIME_BITS-1:0]      m_next_delay,
    output logic                                m_last
);
    import sdtq_pkg::*;

    // item registers
    logic [ACT_W-1:0]     action_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [TIME_BITS-1:0] sum_reg;
    logic                 empty_reg;

    // queue state
    logic [SLOT_W-1:0]    order_reg    [ENTRIES];
    logic [TIME_BITS-1:0] deadline_reg [ENTRIES];
    logic [ENTRIES-1:0]   flag_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [TIME_BITS-1:0] stored_reg;
    logic [CNT_W-1:0]     idx_reg;

    // result word
    logic                 m_valid_reg;
    logic [KIND_W-1:0]    kind_reg;
    logic [SLOT_W-1:0]    which_reg;
    logic                 pend_reg;
    logic                 wempty_reg;
    logic [TIME_BITS-1:0] ndelay_reg;
    logic                 last_reg;

    logic [TIME_BITS:0]   sum_wide;
    logic [TIME_BITS-1:0] sum_sat;
    logic                 in_slot_ok;
    logic [SLOT_W-1:0]    order_rd;
    logic [TIME_BITS-1:0] dl_rd;
    logic                 out_free;
    logic                 emit_any;
    logic                 shift_left;
    logic                 can_insert;

    // saturating deadline from the stored time
    assign sum_wide   = {1'b0, stored_reg} + (TIME_BITS + 1)'(s_delay);
    assign sum_sat    = sum_wide[TIME_BITS] ? '1 : sum_wide[TIME_BITS-1:0];
    assign in_slot_ok = ({1'b0, s_slot} < ENTRY_CNT);

    assign order_rd = order_reg[idx_reg[IDX_W-1:0]];
    assign dl_rd    = deadline_reg[order_rd];
    assign out_free = !m_valid_reg || m_ready;
    assign emit_any = cmd.emit_cancel || cmd.pop || cmd.call_emit || cmd.emit_done;

    assign sts.action     = action_reg;
    assign sts.slot_ok    = ({1'b0, slot_reg} < ENTRY_CNT);
    assign sts.pending    = flag_reg[slot_reg];
    assign sts.idx_lt_cnt = (idx_reg < count_reg);
    assign sts.match      = sts.idx_lt_cnt && (order_rd == slot_reg);
    assign sts.later      = (sum_reg > dl_rd);
    assign sts.expired    = (count_reg != '0) && (dl_rd <= stored_reg);
    assign sts.out_free   = out_free;

    assign shift_left = (cmd.unlink && sts.match) || cmd.pop;
    assign can_insert = cmd.insert && (count_reg < ENTRY_CNT);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg    <= '0;
            count_reg   <= '0;
            stored_reg  <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                idx_reg <= '0;
                if (s_action == ACT_RUN) stored_reg <= s_now;
            end else if (cmd.unlink) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc || cmd.call_emit) begin
                idx_reg <= idx_reg + CNT_W'(1);
            end

            if (cmd.unlink) flag_reg[slot_reg] <= 1'b0;
            if (can_insert) flag_reg[slot_reg] <= 1'b1;
            if (cmd.pop || cmd.call_emit) flag_reg[order_rd] <= 1'b0;

            if (shift_left) count_reg <= count_reg - CNT_W'(1);
            else if (can_insert) count_reg <= count_reg + CNT_W'(1);
            else if (cmd.call_clear) count_reg <= '0;

            if (emit_any) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // list storage, deadlines and item payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= s_action;
            slot_reg   <= s_slot;
            sum_reg    <= sum_sat;
            empty_reg  <= (count_reg == '0);
            if (s_action == ACT_REARM && in_slot_ok) begin
                deadline_reg[s_slot] <= sum_sat;
            end
        end
        if (shift_left) begin
            for (int j = 0; j < ENTRIES - 1; j++) begin
                if (CNT_W'(j) >= idx_reg) order_reg[j] <= order_reg[j + 1];
            end
        end
        if (can_insert) begin
            for (int j = 1; j < ENTRIES; j++) begin
                if (CNT_W'(j) > idx_reg) order_reg[j] <= order_reg[j - 1];
            end
            order_reg[idx_reg[IDX_W-1:0]] <= slot_reg;
        end
    end

    // result word payload
    always_ff @(posedge aclk) begin
        if (emit_any) begin
            kind_reg   <= cmd.pop ? KIND_EXPIRED :
                          cmd.emit_done ? KIND_DONE : KIND_CANCELLED;
            which_reg  <= (cmd.pop || cmd.call_emit) ? order_rd : slot_reg;
            pend_reg   <= cmd.emit_done && (action_reg == ACT_QUERY) && sts.slot_ok &&
                          sts.pending;
            wempty_reg <= cmd.emit_done && (action_reg == ACT_RUN) && empty_reg;
            ndelay_reg <= (cmd.emit_done && (action_reg == ACT_RUN) && (count_reg != '0))
                          ? (dl_rd - stored_reg) : '0;
            last_reg   <= cmd.emit_done;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = kind_reg;
    assign m_which_slot = which_reg;
    assign m_is_pending = pend_reg;
    assign m_was_empty  = wempty_reg;
    assign m_next_delay = ndelay_reg;
    assign m_last       = last_reg;

    `SDTQ_ASSERT(a_count_range, aclk, aresetn, 1'b1, count_reg <= ENTRY_CNT, "queued count beyond capacity")
    `SDTQ_ASSERT(a_no_overwrite, aclk, aresetn, m_valid_reg && !m_ready, !emit_any, "result word overwritten while stalled")
    `SDTQ_ASSERT_NEXT(a_insert_grows, aclk, aresetn, can_insert, count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow the queue")

endmodule

@@ design/sorted_deadline_timer_queue.sv @@
// top level of the sorted deadline timer queue
//
// input channel (s_*): one word per timer action: rearm, cancel, query,
// run at time, cancel all. s_ready is high only while the block is idle,
// so one action is worked on at a time.
// result channel (m_*): each action gives zero or more expired/cancelled
// words followed by one completion word with m_last set.
// each accepted action is decoded first; rearm walks the list once to
// unlink (if pending) and once to find its place, one entry per cycle;
// run and cancel all emit a word per expired or queued entry, held by a
// stalled receiver; query and idle-slot cancel go to the completion word.
// the walk rate is set by the single walk index over the ordered slot list.
// a single output register holds the current result word; when the
// receiver stalls, the controller waits before producing the next word,
// but list walks, unlinks and inserts can go on while a word is held.
// reset (aresetn low, synchronous) empties the queue, clears all pending
// flags and the stored time; no clearing pass is needed.
module sorted_deadline_timer_queue (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [sdtq_pkg::ACT_W-1:0]          s_action,
    input  logic [sdtq_pkg::SLOT_W-1:0]         s_slot,
    input  logic [sdtq_pkg::DELAY_W-1:0]        s_delay,
    input  logic [sdtq_pkg::TIME_BITS-1:0]      s_now,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sdtq_pkg::KIND_W-1:0]         m_kind,
    output logic [sdtq_pkg::SLOT_W-1:0]         m_which_slot,
    output logic                                m_is_pending,
    output logic                                m_was_empty,
    output logic [sdtq_pkg::TIME_BITS-1:0]      m_next_delay,
    output logic                                m_last
);
    import sdtq_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer: one state per phase of an action
    sdtq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // ordered slot list, deadlines, stored time and the result word
    sdtq_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_action     (s_action),
        .s_slot       (s_slot),
        .s_delay      (s_delay),
        .s_now        (s_now),
        .cmd          (cmd),
        .sts          (sts),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_kind       (m_kind),
        .m_which_slot (m_which_slot),
        .m_is_pending (m_is_pending),
        .m_was_empty  (m_was_empty),
        .m_next_delay (m_next_delay),
        .m_last       (m_last)
    );

endmodule
